/* rtl/bi2d_pkg.sv */
// ----------------------------------------------------------------------------
// bi2d_pkg: shared constants and types
// Table sizes, operation codes, sequencer step codes and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bi2d_pkg;

  // Table sizes
  localparam int MAX_POINTS_ONE = 64;
  localparam int MAX_POINTS_TWO = 64;
  localparam int AW1            = $clog2(MAX_POINTS_ONE);
  localparam int AW2            = $clog2(MAX_POINTS_TWO);
  localparam int CNT_W          = 7;

  // Item field widths
  localparam int DW    = 32;
  localparam int ACC_W = 99;
  localparam int MAG_W = 98;

  // Operation codes
  localparam logic [1:0] OP_WR_ONE = 2'd0;
  localparam logic [1:0] OP_WR_TWO = 2'd1;
  localparam logic [1:0] OP_WR_VAL = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_POINTS_ONE = 1'b0;
  localparam logic CFG_POINTS_TWO = 1'b1;

  // Sequencer steps, also the controller state codes
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
  localparam logic [STEP_W-1:0] STEP_RD0  = 5'd1;
  localparam logic [STEP_W-1:0] STEP_RDN  = 5'd2;
  localparam logic [STEP_W-1:0] STEP_CHK  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_SA   = 5'd4;
  localparam logic [STEP_W-1:0] STEP_SB   = 5'd5;
  localparam logic [STEP_W-1:0] STEP_G0   = 5'd6;
  localparam logic [STEP_W-1:0] STEP_G1   = 5'd7;
  localparam logic [STEP_W-1:0] STEP_G2   = 5'd8;
  localparam logic [STEP_W-1:0] STEP_DW   = 5'd9;
  localparam logic [STEP_W-1:0] STEP_DEN  = 5'd10;
  localparam logic [STEP_W-1:0] STEP_VA   = 5'd11;
  localparam logic [STEP_W-1:0] STEP_P0   = 5'd12;
  localparam logic [STEP_W-1:0] STEP_P1   = 5'd13;
  localparam logic [STEP_W-1:0] STEP_ACC  = 5'd14;
  localparam logic [STEP_W-1:0] STEP_NEG  = 5'd15;
  localparam logic [STEP_W-1:0] STEP_SATC = 5'd16;
  localparam logic [STEP_W-1:0] STEP_DIV  = 5'd17;
  localparam logic [STEP_W-1:0] STEP_FIN  = 5'd18;

  // Controller to datapath
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [1:0]        corner;
  } bi2d_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;
    logic zero_w;
    logic sat;
    logic div_last;
    logic out_free;
  } bi2d_stat_t;

  // Clamp a point count to the range 2..max
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n,
                                                   input int max_n);
    logic [CNT_W-1:0] r;
    if (n < CNT_W'(2)) r = CNT_W'(2);
    else if (32'(n) > max_n) r = CNT_W'(max_n);
    else r = n;
    return r;
  endfunction

  // Magnitude of a 33-bit signed value, which always fits 32 bits here
  function automatic logic [DW-1:0] mag33(input logic signed [DW:0] v);
    logic [DW:0] m;
    m = v[DW] ? 33'(-v) : 33'(v);
    return m[DW-1:0];
  endfunction

endpackage

/* rtl/bi2d_ctrl.sv */
// ----------------------------------------------------------------------------
// bi2d_ctrl: query sequencer
// Steps the datapath through table search, corner fetch, accumulation and
// division for one query at a time.
// ----------------------------------------------------------------------------
module bi2d_ctrl
  import bi2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       is_query,
  output logic       in_tready,
  input  bi2d_stat_t stat,
  output bi2d_cmd_t  cmd
);

  logic [STEP_W-1:0] state_r, state_nxt;
  logic [1:0]        corner_r, corner_nxt;

  assign in_tready  = (state_r == STEP_IDLE);
  assign cmd.step   = state_r;
  assign cmd.corner = corner_r;

  // Next-state logic
  always_comb begin
    state_nxt  = state_r;
    corner_nxt = corner_r;
    case (state_r)
      STEP_IDLE: begin
        corner_nxt = 2'd0;
        if (in_tvalid && is_query) state_nxt = STEP_RD0;
      end
      STEP_RD0:  state_nxt = STEP_RDN;
      STEP_RDN:  state_nxt = STEP_CHK;
      STEP_CHK:  state_nxt = STEP_SA;
      STEP_SA:   state_nxt = stat.more ? STEP_SB : STEP_G0;
      STEP_SB:   state_nxt = STEP_SA;
      STEP_G0:   state_nxt = STEP_G1;
      STEP_G1:   state_nxt = STEP_G2;
      STEP_G2:   state_nxt = STEP_DW;
      STEP_DW:   state_nxt = STEP_DEN;
      STEP_DEN:  state_nxt = STEP_VA;
      STEP_VA:   state_nxt = stat.zero_w ? STEP_FIN : STEP_P0;
      STEP_P0:   state_nxt = STEP_P1;
      STEP_P1:   state_nxt = STEP_ACC;
      STEP_ACC: begin
        corner_nxt = corner_r + 2'd1;
        state_nxt  = (corner_r == 2'd3) ? STEP_NEG : STEP_VA;
      end
      STEP_NEG:  state_nxt = STEP_SATC;
      STEP_SATC: state_nxt = stat.sat ? STEP_FIN : STEP_DIV;
      STEP_DIV:  state_nxt = stat.div_last ? STEP_FIN : STEP_DIV;
      STEP_FIN:  state_nxt = stat.out_free ? STEP_IDLE : STEP_FIN;
      default:   state_nxt = STEP_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= STEP_IDLE;
      corner_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
    end
  end

endmodule

/* rtl/bi2d_dp.sv */
// ----------------------------------------------------------------------------
// bi2d_dp: tables and arithmetic
// Holds the point and value tables, the search registers of both axes, the
// split multiplier, the accumulator, the restoring divider and the output
// register.
// ----------------------------------------------------------------------------
module bi2d_dp
  import bi2d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [1:0]        in_op,
  input  logic [AW1-1:0]    in_row,
  input  logic [AW2-1:0]    in_col,
  input  logic signed [DW-1:0] in_wdata,
  input  logic signed [DW-1:0] in_q1,
  input  logic signed [DW-1:0] in_q2,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  bi2d_cmd_t         cmd,
  output bi2d_stat_t        stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic signed [DW-1:0] out_result,
  output logic [1:0]        out_status
);

  localparam int LW = CNT_W;

  // Tables
  logic signed [DW-1:0] mem_one [MAX_POINTS_ONE];
  logic signed [DW-1:0] mem_two [MAX_POINTS_TWO];
  logic signed [DW-1:0] mem_val [MAX_POINTS_ONE*MAX_POINTS_TWO];

  logic [CNT_W-1:0] npts_one_r, npts_two_r;
  logic [CNT_W-1:0] n_one, n_two;

  logic signed [DW-1:0] q_one_r, q_two_r;
  logic signed [DW-1:0] rd_one_r, rd_two_r, rd_val_r;
  logic [AW1-1:0] addr_one;
  logic [AW2-1:0] addr_two;
  logic [AW1+AW2-1:0] addr_val;

  // Search state per axis
  logic [AW1-1:0] lo_one_r;
  logic [AW2-1:0] lo_two_r;
  logic [LW-1:0]  len_one_r, len_two_r;
  logic [LW-1:0]  half_one, half_two;
  logic           le0_one_r, le0_two_r;
  logic signed [DW-1:0] gl_one_r, gl_two_r;
  logic signed [DW:0]   da_one_r, db_one_r, da_two_r, db_two_r;
  logic signed [DW:0]   w_one_r, w_two_r;

  // Arithmetic
  logic [2*DW-1:0]   den_r, m_r;
  logic              zw_r, sgn_r, vs_r;
  logic [DW-1:0]     vmag_r;
  logic [2*DW-1:0]   plo_r, phi_r;
  logic signed [ACC_W-1:0] acc_r;
  logic              neg_r, sat_r;
  logic [MAG_W-1:0]  rem_r, dd_r;
  logic [DW-1:0]     quo_r;
  logic [4:0]        div_cnt_r;
  logic              out_valid_r;
  logic signed [DW-1:0] out_result_r;
  logic [1:0]        out_status_r;

  logic signed [DW:0] d1_sel, d2_sel;
  logic [DW-1:0]      vmag;
  logic [3*DW-1:0]    term;
  logic [AW1-1:0]     row_c;
  logic [AW2-1:0]     col_c;

  assign n_one    = clamp_count(npts_one_r, MAX_POINTS_ONE);
  assign n_two    = clamp_count(npts_two_r, MAX_POINTS_TWO);
  assign half_one = len_one_r >> 1;
  assign half_two = len_two_r >> 1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npts_one_r <= CNT_W'(64);
      npts_two_r <= CNT_W'(64);
    end else if (cfg_we) begin
      if (cfg_index == CFG_POINTS_ONE) npts_one_r <= cfg_wdata;
      else npts_two_r <= cfg_wdata;
    end
  end

  // Read addresses of the point tables for each step
  always_comb begin
    addr_one = '0;
    addr_two = '0;
    case (cmd.step)
      STEP_RDN: begin
        addr_one = AW1'(n_one - CNT_W'(2));
        addr_two = AW2'(n_two - CNT_W'(2));
      end
      STEP_SA: begin
        addr_one = AW1'(LW'(lo_one_r) + half_one);
        addr_two = AW2'(LW'(lo_two_r) + half_two);
      end
      STEP_G0: begin
        addr_one = lo_one_r;
        addr_two = lo_two_r;
      end
      STEP_G1: begin
        addr_one = lo_one_r + AW1'(1);
        addr_two = lo_two_r + AW2'(1);
      end
      default: begin
        addr_one = '0;
        addr_two = '0;
      end
    endcase
  end

  // Corner selection
  assign row_c    = lo_one_r + AW1'(cmd.corner[1]);
  assign col_c    = lo_two_r + AW2'(cmd.corner[0]);
  assign addr_val = {row_c, col_c};
  assign d1_sel   = cmd.corner[1] ? db_one_r : da_one_r;
  assign d2_sel   = cmd.corner[0] ? db_two_r : da_two_r;
  assign vmag     = mag33({rd_val_r[DW-1], rd_val_r});
  assign term     = {phi_r, {DW{1'b0}}} + {{DW{1'b0}}, plo_r};

  // Point table, axis one
  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_WR_ONE) mem_one[in_row] <= in_wdata;
    rd_one_r <= mem_one[addr_one];
  end

  // Point table, axis two
  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_WR_TWO) mem_two[in_col] <= in_wdata;
    rd_two_r <= mem_two[addr_two];
  end

  // Value table
  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_WR_VAL) mem_val[{in_row, in_col}] <= in_wdata;
    rd_val_r <= mem_val[addr_val];
  end

  // Search, corner fetch and offsets
  always_ff @(posedge clk) begin
    case (cmd.step)
      STEP_IDLE: begin
        if (in_fire) begin
          q_one_r <= in_q1;
          q_two_r <= in_q2;
        end
      end
      STEP_RDN: begin
        le0_one_r <= (q_one_r <= rd_one_r);
        le0_two_r <= (q_two_r <= rd_two_r);
      end
      STEP_CHK: begin
        if (le0_one_r) begin
          lo_one_r <= '0; len_one_r <= LW'(1);
        end else if (q_one_r >= rd_one_r) begin
          lo_one_r <= AW1'(n_one - CNT_W'(2)); len_one_r <= LW'(1);
        end else begin
          lo_one_r <= '0; len_one_r <= n_one;
        end
        if (le0_two_r) begin
          lo_two_r <= '0; len_two_r <= LW'(1);
        end else if (q_two_r >= rd_two_r) begin
          lo_two_r <= AW2'(n_two - CNT_W'(2)); len_two_r <= LW'(1);
        end else begin
          lo_two_r <= '0; len_two_r <= n_two;
        end
      end
      STEP_SB: begin
        if (half_one != '0) begin
          if (rd_one_r <= q_one_r) lo_one_r <= AW1'(LW'(lo_one_r) + half_one);
          len_one_r <= len_one_r - half_one;
        end
        if (half_two != '0) begin
          if (rd_two_r <= q_two_r) lo_two_r <= AW2'(LW'(lo_two_r) + half_two);
          len_two_r <= len_two_r - half_two;
        end
      end
      STEP_G1: begin
        gl_one_r <= rd_one_r;
        gl_two_r <= rd_two_r;
      end
      STEP_G2: begin
        da_one_r <= (DW+1)'(rd_one_r) - (DW+1)'(q_one_r);
        db_one_r <= (DW+1)'(q_one_r) - (DW+1)'(gl_one_r);
        w_one_r  <= (DW+1)'(rd_one_r) - (DW+1)'(gl_one_r);
        da_two_r <= (DW+1)'(rd_two_r) - (DW+1)'(q_two_r);
        db_two_r <= (DW+1)'(q_two_r) - (DW+1)'(gl_two_r);
        w_two_r  <= (DW+1)'(rd_two_r) - (DW+1)'(gl_two_r);
      end
      default: begin
      end
    endcase
  end

  // Multiply, accumulate and divide
  always_ff @(posedge clk) begin
    case (cmd.step)
      STEP_DW: begin
        den_r <= mag33(w_one_r) * mag33(w_two_r);
        zw_r  <= (w_one_r == '0) || (w_two_r == '0);
        acc_r <= '0;
      end
      STEP_VA: begin
        m_r   <= mag33(d1_sel) * mag33(d2_sel);
        sgn_r <= d1_sel[DW] ^ d2_sel[DW];
      end
      STEP_P0: begin
        vmag_r <= vmag;
        vs_r   <= rd_val_r[DW-1];
        plo_r  <= m_r[DW-1:0] * vmag;
      end
      STEP_P1: phi_r <= m_r[2*DW-1:DW] * vmag_r;
      STEP_ACC: begin
        if (sgn_r ^ vs_r) acc_r <= acc_r - $signed(ACC_W'(term));
        else acc_r <= acc_r + $signed(ACC_W'(term));
      end
      STEP_NEG: begin
        neg_r <= acc_r[ACC_W-1] ^ w_one_r[DW] ^ w_two_r[DW];
        rem_r <= acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
      end
      STEP_SATC: begin
        sat_r     <= rem_r >= {2'b00, den_r, {DW{1'b0}}};
        dd_r      <= {3'b000, den_r, {(DW-1){1'b0}}};
        quo_r     <= '0;
        div_cnt_r <= '0;
      end
      STEP_DIV: begin
        if (rem_r >= dd_r) begin
          rem_r <= rem_r - dd_r;
          quo_r <= {quo_r[DW-2:0], 1'b1};
        end else begin
          quo_r <= {quo_r[DW-2:0], 1'b0};
        end
        dd_r      <= dd_r >> 1;
        div_cnt_r <= div_cnt_r + 5'd1;
      end
      default: begin
      end
    endcase
  end

  // Output register; it frees up as soon as the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step == STEP_FIN && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result formatting with saturation
  always_ff @(posedge clk) begin
    if (cmd.step == STEP_FIN && (!out_valid_r || out_tready)) begin
      if (zw_r) begin
        out_result_r <= '0;
        out_status_r <= ST_ZERO;
      end else if (neg_r) begin
        if (sat_r || quo_r > 32'h8000_0000) begin
          out_result_r <= 32'sh8000_0000;
          out_status_r <= ST_SAT;
        end else begin
          out_result_r <= -$signed(quo_r);
          out_status_r <= ST_OK;
        end
      end else begin
        if (sat_r || quo_r > 32'h7FFF_FFFF) begin
          out_result_r <= 32'sh7FFF_FFFF;
          out_status_r <= ST_SAT;
        end else begin
          out_result_r <= $signed(quo_r);
          out_status_r <= ST_OK;
        end
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_result    = out_result_r;
  assign out_status    = out_status_r;
  assign stat.more     = (len_one_r > LW'(1)) || (len_two_r > LW'(1));
  assign stat.zero_w   = zw_r;
  assign stat.sat      = rem_r >= {2'b00, den_r, {DW{1'b0}}};
  assign stat.div_last = (div_cnt_r == 5'd31);
  assign stat.out_free = !out_valid_r || out_tready;

endmodule

/* rtl/bilinear_interp_2d_search_unit.sv */
// Queries: a new query is taken only while the sequencer is idle, after the previous query has
// left its final step; the restoring divider dominates the time that a query takes.
// Writes: taken one per cycle while no query is in progress.
// A stalled result holds the sequencer in its last step until the transfer completes.
// Reset: synchronous active low; clears the sequencer and output valid, and sets the point counts to 64.
// ----------------------------------------------------------------------------
// bilinear_interp_2d_search_unit: bilinear interpolation on a rectilinear grid
// Loads grid-point and value tables from write items and answers queries with
// a saturating Q16.16 interpolated value.
// ----------------------------------------------------------------------------
module bilinear_interp_2d_search_unit
  import bi2d_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[1:0], row_index[7:2], col_index[13:8], write_data[45:14],
  // query_one[77:46], query_two[109:78], zero fill [111:110]
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // interp_result[31:0], status[33:32], zero fill [39:34]
  output logic [39:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_wdata
);

  bi2d_cmd_t         cmd;
  bi2d_stat_t        stat;
  logic              in_fire;
  logic signed [DW-1:0] out_result;
  logic [1:0]        out_status;

  assign in_fire = in_tvalid && in_tready;

  // Sequencer
  bi2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .is_query  (in_tdata[1:0] == OP_QUERY),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Tables and arithmetic
  bi2d_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_op      (in_tdata[1:0]),
    .in_row     (in_tdata[7:2]),
    .in_col     (in_tdata[13:8]),
    .in_wdata   (in_tdata[45:14]),
    .in_q1      (in_tdata[77:46]),
    .in_q2      (in_tdata[109:78]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (out_result),
    .out_status (out_status)
  );

  assign out_tdata = {6'b0, out_status, out_result};

endmodule

/* rtl/bi2d_checker.sv */
// ----------------------------------------------------------------------------
// bi2d_checker: port-level checks
// Watches the result channel of the interpolation unit.
// ----------------------------------------------------------------------------
module bi2d_checker
  import bi2d_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // No result is offered right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Only defined status codes appear
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] != 2'b11)
    else $error("undefined status");

  // A zero-width interval gives a zero value
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == ST_ZERO |-> out_tdata[31:0] == 32'd0)
    else $error("zero-width result not zero");

  // A saturated value sits at a bound
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == ST_SAT |->
      out_tdata[31:0] == 32'h7FFF_FFFF || out_tdata[31:0] == 32'h8000_0000)
    else $error("saturated value off bound");

endmodule

bind bilinear_interp_2d_search_unit bi2d_checker u_bi2d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
